// ===== sv/sti_pkg.sv =====
// ============================================================================
// Segment/triangle intersect package
// Widths, pipeline stage map, the per-stage record and small helpers.
// ============================================================================
package sti_pkg;

   // coordinate and arithmetic widths
   localparam int CW   = 20;            // Q12.8 coordinate
   localparam int DW   = CW + 1;        // coordinate difference
   localparam int PW   = 2 * DW;        // difference product
   localparam int XW   = PW + 1;        // cross product component
   localparam int RW   = 30;            // reduced magnitude bits
   localparam int SHW  = 4;             // reduce shift amount
   localparam int SQW  = 2 * RW;        // square
   localparam int SW   = SQW + 2;       // sum of squares
   localparam int RT_N = SW / 2;        // root digits
   localparam int LW   = RT_N;          // length
   localparam int NF   = 14;            // normal fraction bits
   localparam int NW   = 16;            // normal component
   localparam int NQ   = NF + 1;        // normal quotient bits
   localparam int NDW  = RW + NQ + 1;   // normal remainder
   localparam int DPW  = DW + NW;       // distance product
   localparam int DDW  = DPW + 2;       // plane distance
   localparam int DENW = DDW + 1;       // |d1|+|d2|
   localparam int ALO  = 20;            // low slice of |d1|
   localparam int AHI  = DDW - ALO;     // high slice of |d1|
   localparam int N2W  = DW + DDW + 2;  // point dividend
   localparam int Q2   = DW;            // point quotient bits
   localparam int XLO  = 22;            // low slice of edge cross component
   localparam int EHW  = XW - XLO + NW;
   localparam int ELW  = XLO + 1 + NW;
   localparam int EW   = 64;            // edge dot sum

   // pipeline stage map
   localparam int ST_DIF = 0;
   localparam int ST_XP  = 1;
   localparam int ST_CRS = 2;
   localparam int ST_MAG = 3;
   localparam int ST_RED = 4;
   localparam int ST_SQ  = 5;
   localparam int ST_SUM = 6;
   localparam int ST_RT  = 7;
   localparam int ST_ND  = ST_RT + RT_N;
   localparam int ST_NRM = ST_ND + NQ;
   localparam int ST_DP  = ST_NRM + 1;
   localparam int ST_DOT = ST_DP + 1;
   localparam int ST_DEN = ST_DOT + 1;
   localparam int ST_PP  = ST_DEN + 1;
   localparam int ST_NUM = ST_PP + 1;
   localparam int ST_QD  = ST_NUM + 1;
   localparam int ST_PT  = ST_QD + Q2;
   localparam int ST_EAB = ST_PT + 1;
   localparam int ST_EXP = ST_EAB + 1;
   localparam int ST_EX  = ST_EXP + 1;
   localparam int ST_EN  = ST_EX + 1;
   localparam int ST_ET  = ST_EN + 1;
   localparam int ST_ES  = ST_ET + 1;
   localparam int NSTG   = ST_ES + 1;

   localparam int NMAX = 1 << NF;

   // operand picks for the six cross product terms
   localparam int XA [6] = '{1, 2, 2, 0, 0, 1};
   localparam int XB [6] = '{2, 1, 0, 2, 1, 0};

   typedef logic [3*CW-1:0]        word_type;
   typedef logic signed [CW-1:0]   crd_type;

   typedef struct packed {
      word_type                     va, vb, vc, ss, se;
      logic [2:0][DW-1:0]           e1, e2;
      logic [5:0][PW-1:0]           xp;
      logic [2:0][XW-1:0]           c;
      logic [2:0][XW-1:0]           m;
      logic [2:0]                   sgn;
      logic [2:0][RW-1:0]           mr;
      logic [2:0][SQW-1:0]          sq;
      logic [SW-1:0]                rx;
      logic [SW-1:0]                rres;
      logic [LW-1:0]                len;
      logic [2:0][NDW-1:0]          nr;
      logic [2:0][NQ-1:0]           nq;
      logic [2:0][NW-1:0]           n;
      logic [5:0][DPW-1:0]          dp;
      logic [DDW-1:0]               d1, d2;
      logic                         pv;
      logic [DDW-1:0]               a1;
      logic [DENW-1:0]              den;
      logic [2:0][DW-1:0]           dm;
      logic [2:0]                   dn;
      logic [2:0][ALO+DW-1:0]       plo;
      logic [2:0][AHI+DW-1:0]       phi;
      logic [2:0][N2W-1:0]          r2;
      logic [DENW:0]                dv2;
      logic [2:0][Q2-1:0]           q2;
      logic [2:0][CW-1:0]           pt;
      logic [2:0][2:0][DW-1:0]      ea, eb;
      logic [2:0][5:0][PW-1:0]      ep;
      logic [2:0][2:0][XW-1:0]      ex;
      logic [2:0][2:0][EHW-1:0]     ehi;
      logic [2:0][2:0][ELW-1:0]     elo;
      logic [2:0][2:0][EW-1:0]      et;
      logic                         hit;
      logic [3*CW-1:0]              hp;
   } pipe_type;

   function automatic crd_type crd(input word_type w, input int ax);
      return w[ax*CW +: CW];
   endfunction

   function automatic logic [PW-1:0] smul(input logic [DW-1:0] a, input logic [DW-1:0] b);
      return $signed(a) * $signed(b);
   endfunction

endpackage

// ===== sv/segment_triangle_intersect.sv =====
// ============================================================================
// Segment/triangle intersect
// Streams segment/triangle tests: unit normal, plane crossing point and
// inside test, one result beat for every request beat.
// ============================================================================
//
//   channel | prefix | direction | payload
//   --------+--------+-----------+------------------------------------------
//   request | req_   | in        | vertex_a/b/c, seg_start, seg_end (60 each)
//   result  | rsp_   | out       | hit, point_valid, hit_point, unit_normal
//
// One beat enters per cycle unless the pipeline is stalled; it has NSTG stages.
// Most of the stages belong to the 31-step square root, the 15-bit normal divide and
// the 21-bit point divide, each one digit per stage.
// Reset (synchronous, active high) clears only the stage valid bits.
// A stalled result freezes the whole pipeline; req_stall follows it.
//
module segment_triangle_intersect import sti_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3*CW-1:0]   req_vertex_a,
   input  logic [3*CW-1:0]   req_vertex_b,
   input  logic [3*CW-1:0]   req_vertex_c,
   input  logic [3*CW-1:0]   req_seg_start,
   input  logic [3*CW-1:0]   req_seg_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic              rsp_point_valid,
   output logic [3*CW-1:0]   rsp_hit_point,
   output logic [3*NW-1:0]   rsp_unit_normal
);

   logic [NSTG-1:0] vld_ff, vld_in;
   pipe_type        pl_ff [NSTG];
   pipe_type        pl_in [NSTG];
   logic            adv;

   // advance everything unless the last stage holds a stalled beat
   assign adv       = !(vld_ff[NSTG-1] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_comb begin
      pipe_type               p;
      logic [XW-1:0]          orm;
      logic [SHW-1:0]         sh;
      logic [SW-1:0]          rbit;
      logic [SW:0]            rt_t;
      logic [NDW:0]           ndsh;
      logic [N2W-1:0]         qdsh;
      logic [N2W-1:0]         acc;
      logic [NW-1:0]          qn;
      logic signed [DW-1:0]   w1, w2, dlt;
      logic [DDW-1:0]         a2;
      logic [DW:0]            ofs;
      logic signed [EW-1:0]   th, tl, dsum;
      logic                   ok;
      word_type               vt [3];

      // difference vectors of the triangle
      p    = '0;
      p.va = req_vertex_a;
      p.vb = req_vertex_b;
      p.vc = req_vertex_c;
      p.ss = req_seg_start;
      p.se = req_seg_end;
      for (int i = 0; i < 3; i++) begin
         p.e1[i] = DW'(crd(p.vb, i)) - DW'(crd(p.va, i));
         p.e2[i] = DW'(crd(p.vc, i)) - DW'(crd(p.va, i));
      end
      pl_in[ST_DIF] = p;

      // cross product terms of e2 x e1
      p = pl_ff[ST_XP-1];
      for (int k = 0; k < 6; k++) p.xp[k] = smul(p.e2[XA[k]], p.e1[XB[k]]);
      pl_in[ST_XP] = p;

      p = pl_ff[ST_CRS-1];
      for (int i = 0; i < 3; i++)
         p.c[i] = XW'($signed(p.xp[2*i])) - XW'($signed(p.xp[2*i+1]));
      pl_in[ST_CRS] = p;

      p = pl_ff[ST_MAG-1];
      for (int i = 0; i < 3; i++) begin
         p.sgn[i] = p.c[i][XW-1];
         p.m[i]   = p.c[i][XW-1] ? -p.c[i] : p.c[i];
      end
      pl_in[ST_MAG] = p;

      // scale magnitudes below 2^RW
      p   = pl_ff[ST_RED-1];
      orm = p.m[0] | p.m[1] | p.m[2];
      sh  = '0;
      for (int b = RW; b < XW; b++)
         if (orm[b]) sh = SHW'(b - RW + 1);
      for (int i = 0; i < 3; i++) p.mr[i] = RW'(p.m[i] >> sh);
      pl_in[ST_RED] = p;

      p = pl_ff[ST_SQ-1];
      for (int i = 0; i < 3; i++) p.sq[i] = p.mr[i] * p.mr[i];
      pl_in[ST_SQ] = p;

      p      = pl_ff[ST_SUM-1];
      p.rx   = SW'(p.sq[0]) + SW'(p.sq[1]) + SW'(p.sq[2]);
      p.rres = '0;
      pl_in[ST_SUM] = p;

      // square root, one digit per stage
      for (int j = 0; j < RT_N; j++) begin
         p    = pl_ff[ST_RT+j-1];
         rbit = SW'(1) << (2 * (RT_N - 1 - j));
         rt_t = {1'b0, p.rres} + {1'b0, rbit};
         if ({1'b0, p.rx} >= rt_t) begin
            p.rx   = p.rx - rt_t[SW-1:0];
            p.rres = (p.rres >> 1) + rbit;
         end else begin
            p.rres = p.rres >> 1;
         end
         pl_in[ST_RT+j] = p;
      end

      // normal divide: round(m * 2^NF / len), one quotient bit per stage
      for (int j = 0; j < NQ; j++) begin
         p = pl_ff[ST_ND+j-1];
         if (j == 0) begin
            p.len = p.rres[LW-1:0];
            p.nq  = '0;
            for (int i = 0; i < 3; i++)
               p.nr[i] = (NDW'(p.mr[i]) << (NF + 1)) + NDW'(p.len);
         end
         ndsh = (NDW+1)'({p.len, 1'b0}) << (NQ - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if ({1'b0, p.nr[i]} >= ndsh) begin
               p.nr[i]           = p.nr[i] - ndsh[NDW-1:0];
               p.nq[i][NQ-1-j]   = 1'b1;
            end
         end
         pl_in[ST_ND+j] = p;
      end

      // apply sign, zero for a degenerate triangle
      p = pl_ff[ST_NRM-1];
      for (int i = 0; i < 3; i++) begin
         qn     = (p.len == '0) ? '0 : NW'(p.nq[i]);
         p.n[i] = p.sgn[i] ? -qn : qn;
      end
      pl_in[ST_NRM] = p;

      // plane distance products
      p = pl_ff[ST_DP-1];
      for (int i = 0; i < 3; i++) begin
         w1        = DW'(crd(p.ss, i)) - DW'(crd(p.va, i));
         w2        = DW'(crd(p.se, i)) - DW'(crd(p.va, i));
         p.dp[i]   = w1 * $signed(p.n[i]);
         p.dp[3+i] = w2 * $signed(p.n[i]);
      end
      pl_in[ST_DP] = p;

      p    = pl_ff[ST_DOT-1];
      p.d1 = $signed(p.dp[0]) + $signed(p.dp[1]) + $signed(p.dp[2]);
      p.d2 = $signed(p.dp[3]) + $signed(p.dp[4]) + $signed(p.dp[5]);
      pl_in[ST_DOT] = p;

      // crossing decision and divide operands
      p    = pl_ff[ST_DEN-1];
      p.pv = !(($signed(p.d1) > 0 && $signed(p.d2) > 0) ||
               ($signed(p.d1) < 0 && $signed(p.d2) < 0) ||
               (p.d1 == '0 && p.d2 == '0));
      p.a1  = p.d1[DDW-1] ? -p.d1 : p.d1;
      a2    = p.d2[DDW-1] ? -p.d2 : p.d2;
      p.den = DENW'(p.a1) + DENW'(a2);
      for (int i = 0; i < 3; i++) begin
         dlt     = DW'(crd(p.se, i)) - DW'(crd(p.ss, i));
         p.dn[i] = dlt[DW-1];
         p.dm[i] = dlt[DW-1] ? -dlt : dlt;
      end
      pl_in[ST_DEN] = p;

      // |delta| * |d1| as two partial products
      p = pl_ff[ST_PP-1];
      for (int i = 0; i < 3; i++) begin
         p.plo[i] = p.dm[i] * p.a1[ALO-1:0];
         p.phi[i] = p.dm[i] * p.a1[DDW-1:ALO];
      end
      pl_in[ST_PP] = p;

      p     = pl_ff[ST_NUM-1];
      p.dv2 = {p.den, 1'b0};
      p.q2  = '0;
      for (int i = 0; i < 3; i++) begin
         acc     = (N2W'(p.phi[i]) << ALO) + N2W'(p.plo[i]);
         p.r2[i] = (acc << 1) + N2W'(p.den);
      end
      pl_in[ST_NUM] = p;

      // point offset divide, one quotient bit per stage
      for (int j = 0; j < Q2; j++) begin
         p    = pl_ff[ST_QD+j-1];
         qdsh = N2W'(p.dv2) << (Q2 - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (p.r2[i] >= qdsh) begin
               p.r2[i]         = p.r2[i] - qdsh;
               p.q2[i][Q2-1-j] = 1'b1;
            end
         end
         pl_in[ST_QD+j] = p;
      end

      p = pl_ff[ST_PT-1];
      for (int i = 0; i < 3; i++) begin
         ofs     = p.dn[i] ? -((DW+1)'(p.q2[i])) : (DW+1)'(p.q2[i]);
         p.pt[i] = CW'((DW+1)'(crd(p.ss, i)) + ofs);
      end
      pl_in[ST_PT] = p;

      // edge vectors: a = pt - to, b = to - from
      p     = pl_ff[ST_EAB-1];
      vt[0] = p.va;
      vt[1] = p.vb;
      vt[2] = p.vc;
      for (int e = 0; e < 3; e++) begin
         for (int i = 0; i < 3; i++) begin
            p.ea[e][i] = DW'($signed(p.pt[i])) - DW'(crd(vt[(e+1)%3], i));
            p.eb[e][i] = DW'(crd(vt[(e+1)%3], i)) - DW'(crd(vt[e], i));
         end
      end
      pl_in[ST_EAB] = p;

      p = pl_ff[ST_EXP-1];
      for (int e = 0; e < 3; e++)
         for (int k = 0; k < 6; k++) p.ep[e][k] = smul(p.ea[e][XA[k]], p.eb[e][XB[k]]);
      pl_in[ST_EXP] = p;

      p = pl_ff[ST_EX-1];
      for (int e = 0; e < 3; e++)
         for (int i = 0; i < 3; i++)
            p.ex[e][i] = XW'($signed(p.ep[e][2*i])) - XW'($signed(p.ep[e][2*i+1]));
      pl_in[ST_EX] = p;

      // split each cross component against the normal
      p = pl_ff[ST_EN-1];
      for (int e = 0; e < 3; e++) begin
         for (int i = 0; i < 3; i++) begin
            p.ehi[e][i] = $signed(p.ex[e][i][XW-1:XLO]) * $signed(p.n[i]);
            p.elo[e][i] = $signed({1'b0, p.ex[e][i][XLO-1:0]}) * $signed(p.n[i]);
         end
      end
      pl_in[ST_EN] = p;

      p = pl_ff[ST_ET-1];
      for (int e = 0; e < 3; e++) begin
         for (int i = 0; i < 3; i++) begin
            th         = $signed(p.ehi[e][i]);
            tl         = $signed(p.elo[e][i]);
            p.et[e][i] = (th <<< XLO) + tl;
         end
      end
      pl_in[ST_ET] = p;

      // inside test and result formatting
      p  = pl_ff[ST_ES-1];
      ok = 1'b1;
      for (int e = 0; e < 3; e++) begin
         dsum = $signed(p.et[e][0]) + $signed(p.et[e][1]) + $signed(p.et[e][2]);
         if (dsum[EW-1]) ok = 1'b0;
      end
      p.hit = p.pv && ok;
      p.hp  = p.pv ? {p.pt[2], p.pt[1], p.pt[0]} : '0;
      pl_in[ST_ES] = p;
   end

   // stage valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff <= pl_in;
      end
   end

   assign rsp_valid       = vld_ff[NSTG-1];
   assign rsp_hit         = pl_ff[NSTG-1].hit;
   assign rsp_point_valid = pl_ff[NSTG-1].pv;
   assign rsp_hit_point   = pl_ff[NSTG-1].hp;
   assign rsp_unit_normal = {pl_ff[NSTG-1].n[2], pl_ff[NSTG-1].n[1], pl_ff[NSTG-1].n[0]};

`ifndef SYNTHESIS
   a_no_point_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> !rsp_hit && rsp_hit_point == '0)
      else $error("hit or point without a plane crossing");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_unit_normal[NW-1:0]) <= NMAX &&
         $signed(rsp_unit_normal[NW-1:0]) >= -NMAX &&
         $signed(rsp_unit_normal[2*NW-1:NW]) <= NMAX &&
         $signed(rsp_unit_normal[2*NW-1:NW]) >= -NMAX &&
         $signed(rsp_unit_normal[3*NW-1:2*NW]) <= NMAX &&
         $signed(rsp_unit_normal[3*NW-1:2*NW]) >= -NMAX)
      else $error("normal component out of range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule
